// ===== rtl/core/complex_l2_normalizer_core_macros.svh =====
// Assertion macros used by the checker file of the normaliser core.
`ifndef COMPLEX_L2_NORMALIZER_CORE_MACROS_SVH
`define COMPLEX_L2_NORMALIZER_CORE_MACROS_SVH
// Concurrent check on the core clock, disabled while reset is asserted.
`define CLN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that holds even while reset is asserted.
`define CLN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/cln_pkg.sv =====
// Shared types, constants and the helper function of the complex L2 normaliser.
package cln_pkg;
	localparam int MaxElements = 4096;
	localparam int SampleW = 24;
	localparam int AddrW = $clog2(MaxElements);
	localparam int CountW = AddrW + 1;
	localparam int SumW = 60;
	localparam int QuoW = SumW + 1;
	localparam int RootW = 31;
	localparam int OutW = 32;
	localparam int SideW = 5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_ZERO_NORM = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic last;
		logic [AddrW-1:0] addr;
		logic [SumW-1:0] sum;
	} job_t;

	// Element count of a data set: side cubed, a zero side counts as one, saturated.
	function automatic logic [CountW-1:0] elem_count(input logic [SideW-1:0] side);
		logic [SideW-1:0] s;
		logic [3*SideW-1:0] cube;
		s = (side == '0) ? SideW'(1) : side;
		cube = (3*SideW)'(s) * (3*SideW)'(s) * (3*SideW)'(s);
		if (cube > (3*SideW)'(MaxElements))
			return CountW'(MaxElements);
		return CountW'(cube);
	endfunction
endpackage

// ===== rtl/core/cln_ram.sv =====
// Simple dual-port sample memory with registered read data.
module cln_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 48
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/cln_fifo.sv =====
// Four-entry request queue between the front and the back of the normaliser.
module cln_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cln_pkg::job_t din,
	output logic full,
	input  logic pop,
	output cln_pkg::job_t dout,
	output logic empty
);
	import cln_pkg::*;

	job_t buf_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign dout = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			buf_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + 2'd1;
			if (pop && !empty)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && !empty);
		end
	end
endmodule

// ===== rtl/core/cln_front.sv =====
// Front end: accepts requests, stores samples, sums squared magnitudes, issues jobs.
module cln_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic cmd,
	input  logic signed [cln_pkg::SampleW-1:0] sample_re,
	input  logic signed [cln_pkg::SampleW-1:0] sample_im,
	input  logic cfg_we,
	input  logic [cln_pkg::SideW-1:0] cfg_data,
	output logic ram_we,
	output logic [cln_pkg::AddrW-1:0] ram_waddr,
	output logic [2*cln_pkg::SampleW-1:0] ram_wdata,
	output logic job_push,
	output cln_pkg::job_t job,
	input  logic job_full,
	input  logic job_empty,
	input  logic back_busy
);
	import cln_pkg::*;

	logic [CountW-1:0] n_q, load_cnt_q;
	logic [AddrW-1:0] rp_q;
	logic readout_q;
	logic [SumW-1:0] sum_q, sum_next;
	logic [SumW-1:0] add_s1;
	logic add_v_s1;
	logic accept, is_load, is_fetch, last_fetch;
	logic [SampleW-1:0] mag_re, mag_im;

	assign full = job_full || (!cmd && !readout_q && (!job_empty || back_busy));
	assign accept = push && !full;
	assign is_load = accept && !cmd && !readout_q;
	assign is_fetch = accept && cmd;
	assign sum_next = sum_q + (add_v_s1 ? add_s1 : '0);
	assign last_fetch = (CountW'(rp_q) + CountW'(1)) >= n_q;

	assign mag_re = sample_re[SampleW-1] ? SampleW'(-sample_re) : SampleW'(sample_re);
	assign mag_im = sample_im[SampleW-1] ? SampleW'(-sample_im) : SampleW'(sample_im);

	assign ram_we = is_load;
	assign ram_waddr = load_cnt_q[AddrW-1:0];
	assign ram_wdata = {sample_re, sample_im};

	assign job_push = is_fetch;
	always_comb begin
		job.addr = rp_q;
		job.sum = sum_next;
		job.last = 1'b0;
		if (!readout_q)
			job.status = ST_NOT_READY;
		else begin
			job.last = last_fetch;
			job.status = (sum_next == '0) ? ST_ZERO_NORM : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		add_s1 <= SumW'({{SampleW{1'b0}}, mag_re} * {{SampleW{1'b0}}, mag_re}) +
			SumW'({{SampleW{1'b0}}, mag_im} * {{SampleW{1'b0}}, mag_im});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CountW'(MaxElements);
			load_cnt_q <= '0;
			rp_q <= '0;
			readout_q <= 1'b0;
			sum_q <= '0;
			add_v_s1 <= 1'b0;
		end else if (cfg_we) begin
			n_q <= elem_count(cfg_data);
			load_cnt_q <= '0;
			rp_q <= '0;
			readout_q <= 1'b0;
			sum_q <= '0;
			add_v_s1 <= 1'b0;
		end else begin
			sum_q <= (is_fetch && readout_q && last_fetch) ? '0 : sum_next;
			add_v_s1 <= is_load;
			if (is_load) begin
				load_cnt_q <= load_cnt_q + CountW'(1);
				if (load_cnt_q + CountW'(1) >= n_q) begin
					readout_q <= 1'b1;
					rp_q <= '0;
				end
			end
			if (is_fetch && readout_q) begin
				if (last_fetch) begin
					load_cnt_q <= '0;
					rp_q <= '0;
					readout_q <= 1'b0;
				end else
					rp_q <= rp_q + AddrW'(1);
			end
		end
	end
endmodule

// ===== rtl/core/cln_back.sv =====
// Back end: per OK job, divides each squared component by the sum and takes the root.
module cln_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_empty,
	input  cln_pkg::job_t job,
	output logic job_pop,
	output logic busy,
	output logic ram_re,
	output logic [cln_pkg::AddrW-1:0] ram_raddr,
	input  logic [2*cln_pkg::SampleW-1:0] ram_rdata,
	output logic empty,
	input  logic pop,
	output logic signed [cln_pkg::OutW-1:0] norm_re,
	output logic signed [cln_pkg::OutW-1:0] norm_im,
	output logic is_last,
	output logic [1:0] status
);
	import cln_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_CAP  = 8'b0000_0100,
		S_SQR  = 8'b0000_1000,
		S_DIV  = 8'b0001_0000,
		S_ROOT = 8'b0010_0000,
		S_SIGN = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [2*SampleW-1:0] samp_q;
	logic comp_q;
	logic [5:0] cnt_q;
	logic [QuoW-1:0] rem_q, quo_q, rem_sub;
	logic [RootW-1:0] root_q;
	logic [2*RootW-1:0] rsq_q, trial;
	logic [OutW-1:0] res_re_q, res_im_q, signed_val;
	logic out_v_q;
	logic [SampleW-1:0] x, mag;
	logic ge;
	logic [4:0] bidx;

	assign busy = (state_q != S_IDLE);
	assign job_pop = (state_q == S_IDLE) && !job_empty;
	assign ram_re = (state_q == S_RD);
	assign ram_raddr = job_q.addr;
	assign empty = !out_v_q;

	assign x = comp_q ? samp_q[SampleW-1:0] : samp_q[2*SampleW-1:SampleW];
	assign mag = x[SampleW-1] ? SampleW'(-x) : x;
	assign ge = rem_q >= {1'b0, job_q.sum};
	assign rem_sub = ge ? (rem_q - {1'b0, job_q.sum}) : rem_q;
	assign bidx = cnt_q[4:0];
	assign trial = rsq_q + ({{RootW{1'b0}}, root_q} << (6'(bidx) + 6'd1))
		+ ((2*RootW)'(1) << {bidx, 1'b0});
	assign signed_val = x[SampleW-1] ? OutW'(-{1'b0, root_q}) : OutW'({1'b0, root_q});

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				job_q <= job;
				res_re_q <= '0;
				res_im_q <= '0;
			end
			S_CAP: begin
				samp_q <= ram_rdata;
				comp_q <= 1'b0;
			end
			S_SQR: begin
				rem_q <= QuoW'({{SampleW{1'b0}}, mag} * {{SampleW{1'b0}}, mag});
				quo_q <= '0;
				cnt_q <= 6'(QuoW - 1);
			end
			S_DIV: begin
				quo_q <= {quo_q[QuoW-2:0], ge};
				rem_q <= {rem_sub[QuoW-2:0], 1'b0};
				cnt_q <= (cnt_q == 6'd0) ? 6'(RootW - 1) : cnt_q - 6'd1;
				root_q <= '0;
				rsq_q <= '0;
			end
			S_ROOT: begin
				if (trial <= {1'b0, quo_q}) begin
					root_q <= root_q | (RootW'(1) << bidx);
					rsq_q <= trial;
				end
				cnt_q <= cnt_q - 6'd1;
			end
			S_SIGN: begin
				if (comp_q)
					res_im_q <= signed_val;
				else
					res_re_q <= signed_val;
				comp_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (state_q == S_OUT && !out_v_q) begin
			norm_re <= res_re_q;
			norm_im <= res_im_q;
			is_last <= job_q.last;
			status <= job_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (!job_empty)
					state_q <= (job.status == ST_OK) ? S_RD : S_OUT;
				S_RD: state_q <= S_CAP;
				S_CAP: state_q <= S_SQR;
				S_SQR: state_q <= S_DIV;
				S_DIV: if (cnt_q == 6'd0)
					state_q <= S_ROOT;
				S_ROOT: if (cnt_q == 6'd0)
					state_q <= S_SIGN;
				S_SIGN: state_q <= comp_q ? S_OUT : S_SQR;
				S_OUT: if (!out_v_q) begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/complex_l2_normalizer_core.sv =====
// Top level of the complex L2 normaliser core.
// The core loads one data set of side_length cubed complex samples (cmd 0 requests), storing
// them in a 4096-entry memory and adding up the squared magnitudes, then answers each cmd 1
// request with the next stored sample divided by the root of that sum, in signed Q1.30,
// truncated toward zero, with is_last on the final element. A fetch before the set is
// complete returns status not_ready; an all-zero set returns zeros with status zero_norm;
// loads arriving during readout are accepted and dropped. Writing side_length aborts the
// current set. Loads are taken one per cycle, but a load is held off (full) until every
// earlier fetch has been finished, so that a new set never overwrites a sample still to be
// read. Each fetch that returns data is worked out in the back end, per component by one
// multiply, a 61-step bit-serial divide and a 31-step bit-serial square root, run one after
// the other; status-only fetches skip these steps. Up to four fetch requests wait in the queue
// between front and back, and one finished result waits on the output ports, so fetch
// requests are still accepted while a result is not yet popped, until the queue is full.
module complex_l2_normalizer_core (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic cmd,
	input  logic signed [cln_pkg::SampleW-1:0] sample_re,
	input  logic signed [cln_pkg::SampleW-1:0] sample_im,
	input  logic cfg_we,
	input  logic [cln_pkg::SideW-1:0] cfg_data,
	output logic empty,
	input  logic pop,
	output logic signed [cln_pkg::OutW-1:0] norm_re,
	output logic signed [cln_pkg::OutW-1:0] norm_im,
	output logic is_last,
	output logic [1:0] status
);
	import cln_pkg::*;

	logic ram_we, ram_re;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [2*SampleW-1:0] ram_wdata, ram_rdata;
	logic job_push, job_full, job_empty, job_pop, back_busy;
	job_t job_in, job_out;

	// The front end owns the set state: load count, read pointer and the running sum.
	cln_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .sample_re, .sample_im, .cfg_we, .cfg_data,
		.ram_we, .ram_waddr, .ram_wdata,
		.job_push, .job(job_in), .job_full, .job_empty, .back_busy
	);

	// Each queued job carries its own sum so the back end never sees the next set's state.
	cln_fifo u_fifo (
		.clk, .arst_n, .push(job_push), .din(job_in), .full(job_full),
		.pop(job_pop), .dout(job_out), .empty(job_empty)
	);

	cln_ram #(.DEPTH(MaxElements), .WIDTH(2*SampleW)) u_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	cln_back u_back (
		.clk, .arst_n, .job_empty, .job(job_out), .job_pop, .busy(back_busy),
		.ram_re, .ram_raddr, .ram_rdata,
		.empty, .pop, .norm_re, .norm_im, .is_last, .status
	);
endmodule

// ===== rtl/core/cln_checker.sv =====
// Port-level checker of the normaliser core and its bind statement.
`include "complex_l2_normalizer_core_macros.svh"
module cln_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [cln_pkg::OutW-1:0] norm_re,
	input logic [cln_pkg::OutW-1:0] norm_im,
	input logic is_last,
	input logic [1:0] status
);
	import cln_pkg::*;

	`CLN_ASSERT(a_status_code, !empty |-> (status == ST_OK || status == ST_NOT_READY || status == ST_ZERO_NORM), "bad status code")
	`CLN_ASSERT(a_zero_payload, (!empty && status != ST_OK) |-> (norm_re == '0 && norm_im == '0), "nonzero data with error status")
	`CLN_ASSERT(a_not_ready_last, (!empty && status == ST_NOT_READY) |-> !is_last, "not_ready marked last")
	`CLN_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(norm_re) && $stable(status)), "result changed while waiting")
	`CLN_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> empty, "result shown during reset")
endmodule

bind complex_l2_normalizer_core cln_checker u_cln_checker (
	.clk, .arst_n, .empty, .pop, .norm_re, .norm_im, .is_last, .status
);
